@@ rtl/core/abs_pkg.sv @@
// ----------------------------------------------------------------------------
// abs_pkg
// shared types, codes and defaults of the alternating-bit sender core
// ----------------------------------------------------------------------------
`default_nettype none

package abs_pkg;

   // defaults for the top level parameters
   localparam int MSG_LEN_DEF     = 20;
   localparam int QUEUE_DEPTH_DEF = 4;

   // field widths
   localparam int BYTE_W = 8;
   localparam int SUM_W  = 16;
   localparam int TMO_W  = 16;

   // reset value of the retransmit timeout
   localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd1000;

   // input command codes
   localparam logic [1:0] CMD_MSG    = 2'd0;
   localparam logic [1:0] CMD_ACK    = 2'd1;
   localparam logic [1:0] CMD_EXPIRE = 2'd2;

   // job codes between front and back, equal to the result kind
   localparam logic JOB_SEND = 1'b0;
   localparam logic JOB_STOP = 1'b1;

   // stored packet state, owned by the front, read by the back
   typedef struct packed {
      logic             seq;
      logic [SUM_W-1:0] checksum;
      logic             bank;
      logic             valid;
   } abs_store_type;

endpackage

`default_nettype wire

@@ rtl/core/abs_ram.sv @@
// ----------------------------------------------------------------------------
// abs_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module abs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/abs_fifo.sv @@
// ----------------------------------------------------------------------------
// abs_fifo
// short job queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module abs_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  wire logic push_job,
   input  wire logic pop,
   output logic      head_job,
   output logic      empty,
   output logic      full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic             slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head_job = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/abs_front.sv @@
// ----------------------------------------------------------------------------
// abs_front
// accepts items, assembles messages, checks ack packets, queues jobs
// ----------------------------------------------------------------------------
`default_nettype none

module abs_front #(
   parameter int MSG_LEN = 20,
   parameter int IDX_W   = 5
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // input item
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire logic [1:0]                  command,
   input  wire logic [abs_pkg::BYTE_W-1:0]  data_byte,
   input  wire logic                        pkt_seq,
   input  wire logic                        pkt_ack,
   input  wire logic [abs_pkg::SUM_W-1:0]   pkt_checksum,
   // job queue
   output logic                             job_push,
   output logic                             job_kind,
   input  wire logic                        job_empty,
   input  wire logic                        job_full,
   input  wire logic                        back_idle,
   // payload ram write port
   output logic                             wr_en,
   output logic [IDX_W:0]                   wr_addr,
   output logic [abs_pkg::BYTE_W-1:0]       wr_data,
   // stored packet
   output abs_pkg::abs_store_type           store
);

   import abs_pkg::*;

   localparam int PROD_W = BYTE_W + IDX_W + 1;

   logic             seq_ff, seq_in;
   logic             bank_ff, bank_in;
   logic             stored_ok_ff, stored_ok_in;
   logic [SUM_W-1:0] chk_ff, chk_in;
   logic [IDX_W-1:0] msg_idx_ff, msg_idx_in;
   logic [SUM_W-1:0] msg_sum_ff, msg_sum_in;
   logic [IDX_W-1:0] ack_idx_ff, ack_idx_in;
   logic [SUM_W-1:0] ack_sum_ff, ack_sum_in;

   logic                    accept;
   logic                    msg_last, ack_last;
   logic [IDX_W-1:0]        pos;
   logic signed [PROD_W-1:0] prod;
   logic [SUM_W-1:0]        term;
   logic [SUM_W-1:0]        msg_total, ack_total, ack_calc;
   logic                    ack_good;

   assign msg_last = (command == CMD_MSG) && (msg_idx_ff == IDX_W'(MSG_LEN - 1));
   assign ack_last = (command == CMD_ACK) && (ack_idx_ff == IDX_W'(MSG_LEN - 1));

   // a completing message waits until the back no longer reads the stored bank
   assign in_ready = !job_full && (!msg_last || (job_empty && back_idle));
   assign accept   = in_valid && in_ready;

   // checksum term: signed byte times position plus two
   assign pos       = (command == CMD_MSG) ? msg_idx_ff : ack_idx_ff;
   assign prod      = $signed(data_byte) * $signed({1'b0, pos});
   assign term      = SUM_W'(prod) + SUM_W'(2);
   assign msg_total = msg_sum_ff + term;
   assign ack_total = ack_sum_ff + term;
   assign ack_calc  = ack_total + SUM_W'(pkt_seq) + SUM_W'({pkt_ack, 1'b0});
   assign ack_good  = (ack_calc == pkt_checksum) && (pkt_ack == seq_ff);

   // assembly bank write
   assign wr_en   = accept && (command == CMD_MSG);
   assign wr_addr = {bank_ff, msg_idx_ff};
   assign wr_data = data_byte;

   // state update and job generation
   always_comb begin
      seq_in       = seq_ff;
      bank_in      = bank_ff;
      stored_ok_in = stored_ok_ff;
      chk_in       = chk_ff;
      msg_idx_in   = msg_idx_ff;
      msg_sum_in   = msg_sum_ff;
      ack_idx_in   = ack_idx_ff;
      ack_sum_in   = ack_sum_ff;
      job_push     = 1'b0;
      job_kind     = JOB_SEND;
      if (accept) begin
         unique case (command)
            CMD_MSG: begin
               if (msg_last) begin
                  seq_in       = !seq_ff;
                  chk_in       = msg_total + SUM_W'(!seq_ff);
                  bank_in      = !bank_ff;
                  stored_ok_in = 1'b1;
                  msg_idx_in   = '0;
                  msg_sum_in   = '0;
                  job_push     = 1'b1;
               end else begin
                  msg_idx_in = msg_idx_ff + 1'b1;
                  msg_sum_in = msg_total;
               end
            end
            CMD_ACK: begin
               if (ack_last) begin
                  ack_idx_in = '0;
                  ack_sum_in = '0;
                  job_push   = 1'b1;
                  job_kind   = ack_good ? JOB_STOP : JOB_SEND;
               end else begin
                  ack_idx_in = ack_idx_ff + 1'b1;
                  ack_sum_in = ack_total;
               end
            end
            CMD_EXPIRE: begin
               job_push = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= 1'b1;
         bank_ff      <= 1'b0;
         stored_ok_ff <= 1'b0;
         chk_ff       <= '0;
         msg_idx_ff   <= '0;
         msg_sum_ff   <= '0;
         ack_idx_ff   <= '0;
         ack_sum_ff   <= '0;
      end else begin
         seq_ff       <= seq_in;
         bank_ff      <= bank_in;
         stored_ok_ff <= stored_ok_in;
         chk_ff       <= chk_in;
         msg_idx_ff   <= msg_idx_in;
         msg_sum_ff   <= msg_sum_in;
         ack_idx_ff   <= ack_idx_in;
         ack_sum_ff   <= ack_sum_in;
      end
   end

   // stored bank is the one not being assembled
   always_comb begin
      store.seq      = seq_ff;
      store.checksum = chk_ff;
      store.bank     = !bank_ff;
      store.valid    = stored_ok_ff;
   end

endmodule

`default_nettype wire

@@ rtl/core/abs_back.sv @@
// ----------------------------------------------------------------------------
// abs_back
// takes queued jobs and plays out packet bursts or timer stops
// ----------------------------------------------------------------------------
`default_nettype none

module abs_back #(
   parameter int MSG_LEN = 20,
   parameter int IDX_W   = 5
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // job queue
   input  wire logic                       job_empty,
   input  wire logic                       job_kind,
   output logic                            job_pop,
   // stored packet and timeout
   input  wire abs_pkg::abs_store_type     store,
   input  wire logic [abs_pkg::TMO_W-1:0]  timeout,
   output logic                            idle,
   // payload ram read port
   output logic                            rd_en,
   output logic [IDX_W:0]                  rd_addr,
   input  wire logic [abs_pkg::BYTE_W-1:0] rd_data,
   // result item
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic                            out_kind,
   output logic [abs_pkg::BYTE_W-1:0]      out_byte,
   output logic                            out_seq,
   output logic [abs_pkg::SUM_W-1:0]       out_checksum,
   output logic                            out_last,
   output logic                            timer_restart,
   output logic [abs_pkg::TMO_W-1:0]       timer_value
);

   import abs_pkg::*;

   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;

   // stage 1: ram output register plus its tags
   logic s1_valid_ff, s1_valid_in;
   logic s1_kind_ff, s1_kind_in;
   logic s1_last_ff, s1_last_in;
   logic s1_zero_ff, s1_zero_in;

   // stage 2: result register
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_kind_ff;
   logic [BYTE_W-1:0] s2_byte_ff;
   logic             s2_seq_ff;
   logic [SUM_W-1:0] s2_chk_ff;
   logic             s2_last_ff;
   logic             s2_restart_ff;
   logic [TMO_W-1:0] s2_tmo_ff;

   logic s2_free, s1_move, s1_ready, burst_end;

   assign s2_free   = !s2_valid_ff || out_ready;
   assign s1_move   = s1_valid_ff && s2_free;
   assign s1_ready  = !s1_valid_ff || s2_free;
   assign burst_end = (cnt_ff == IDX_W'(MSG_LEN - 1));

   assign rd_en   = busy_ff && s1_ready;
   assign rd_addr = {store.bank, cnt_ff};
   assign job_pop = !busy_ff && !job_empty && s1_ready;
   assign idle    = !busy_ff && !s1_valid_ff && !s2_valid_ff;

   // burst sequencer and stage 1 load
   always_comb begin
      busy_in     = busy_ff;
      cnt_in      = cnt_ff;
      s1_valid_in = s1_move ? 1'b0 : s1_valid_ff;
      s1_kind_in  = s1_kind_ff;
      s1_last_in  = s1_last_ff;
      s1_zero_in  = s1_zero_ff;
      if (rd_en) begin
         s1_valid_in = 1'b1;
         s1_kind_in  = JOB_SEND;
         s1_last_in  = burst_end;
         s1_zero_in  = !store.valid;
         cnt_in      = cnt_ff + 1'b1;
         if (burst_end) begin
            busy_in = 1'b0;
         end
      end else if (job_pop) begin
         if (job_kind == JOB_STOP) begin
            s1_valid_in = 1'b1;
            s1_kind_in  = JOB_STOP;
            s1_last_in  = 1'b0;
            s1_zero_in  = 1'b1;
         end else begin
            busy_in = 1'b1;
            cnt_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         cnt_ff      <= cnt_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff <= s1_kind_in;
      s1_last_ff <= s1_last_in;
      s1_zero_ff <= s1_zero_in;
   end

   // result register valid
   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s1_move) begin
         s2_valid_in = 1'b1;
      end else if (out_ready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   // result payload, zeroed for a timer stop
   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_kind_ff    <= s1_kind_ff;
         s2_byte_ff    <= s1_zero_ff ? '0 : rd_data;
         s2_last_ff    <= s1_last_ff;
         s2_restart_ff <= s1_last_ff;
         if (s1_kind_ff == JOB_STOP) begin
            s2_seq_ff <= 1'b0;
            s2_chk_ff <= '0;
            s2_tmo_ff <= '0;
         end else begin
            s2_seq_ff <= store.seq;
            s2_chk_ff <= store.checksum;
            s2_tmo_ff <= timeout;
         end
      end
   end

   assign out_valid     = s2_valid_ff;
   assign out_kind      = s2_kind_ff;
   assign out_byte      = s2_byte_ff;
   assign out_seq       = s2_seq_ff;
   assign out_checksum  = s2_chk_ff;
   assign out_last      = s2_last_ff;
   assign timer_restart = s2_restart_ff;
   assign timer_value   = s2_tmo_ff;

endmodule

`default_nettype wire

@@ rtl/core/alternating_bit_sender_core.sv @@
// first byte of a burst passes the job queue, burst sequencer, ram and result registers
// throughput: one input item per cycle while the job queue has room; a message-completing
//   byte waits until the queue and the back are empty, since the stored bank is swapped then
// bursts give MSG_LEN items at one per cycle while rsp_tready holds, set by the ram read port
// reset: synchronous, active high; seq 1, zero stored packet, timeout 1000
// ----------------------------------------------------------------------------
// alternating_bit_sender_core
// stop-and-wait alternating-bit sender: front assembles and checks, a job
// queue decouples it from the back that plays out bursts
// ----------------------------------------------------------------------------
`default_nettype none

module alternating_bit_sender_core #(
   parameter int MSG_LEN     = abs_pkg::MSG_LEN_DEF,
   parameter int QUEUE_DEPTH = abs_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // data_byte, pkt_seq, pkt_ack, pkt_checksum, zero pad
   input  wire logic [1:0]  req_tuser,  // command
   // result items
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // out_byte, out_seq, out_checksum, timer_restart,
                                        // timer_value, zero pad
   output logic [0:0]       rsp_tuser,  // out_kind
   output logic             rsp_tlast,  // out_last
   // configuration
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);

   import abs_pkg::*;

   localparam int IDX_W     = (MSG_LEN > 1) ? $clog2(MSG_LEN) : 1;
   localparam int RAM_DEPTH = 2 ** (IDX_W + 1);

   logic [TMO_W-1:0]  timeout_ff;
   abs_store_type     store;
   logic              job_push, job_kind_w, job_pop, job_head, job_empty, job_full;
   logic              back_idle;
   logic              wr_en, rd_en;
   logic [IDX_W:0]    wr_addr, rd_addr;
   logic [BYTE_W-1:0] wr_data, rd_data;
   logic              out_kind, out_seq, out_last, timer_restart;
   logic [BYTE_W-1:0] out_byte;
   logic [SUM_W-1:0]  out_checksum;
   logic [TMO_W-1:0]  timer_value;

   // retransmit timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_we) begin
         timeout_ff <= csr_wdata;
      end
   end

   // front
   abs_front #(
      .MSG_LEN (MSG_LEN),
      .IDX_W   (IDX_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .command      (req_tuser),
      .data_byte    (req_tdata[7:0]),
      .pkt_seq      (req_tdata[8]),
      .pkt_ack      (req_tdata[9]),
      .pkt_checksum (req_tdata[25:10]),
      .job_push     (job_push),
      .job_kind     (job_kind_w),
      .job_empty    (job_empty),
      .job_full     (job_full),
      .back_idle    (back_idle),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .store        (store)
   );

   // job queue
   abs_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job_kind_w),
      .pop      (job_pop),
      .head_job (job_head),
      .empty    (job_empty),
      .full     (job_full)
   );

   // payload ram, two banks of one packet each
   abs_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // back
   abs_back #(
      .MSG_LEN (MSG_LEN),
      .IDX_W   (IDX_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_empty     (job_empty),
      .job_kind      (job_head),
      .job_pop       (job_pop),
      .store         (store),
      .timeout       (timeout_ff),
      .idle          (back_idle),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_kind      (out_kind),
      .out_byte      (out_byte),
      .out_seq       (out_seq),
      .out_checksum  (out_checksum),
      .out_last      (out_last),
      .timer_restart (timer_restart),
      .timer_value   (timer_value)
   );

   // result packing
   assign rsp_tdata = {6'd0, timer_value, timer_restart, out_checksum, out_seq, out_byte};
   assign rsp_tuser = out_kind;
   assign rsp_tlast = out_last;

endmodule

`default_nettype wire

@@ dv/alternating_bit_sender_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alternating_bit_sender_core_test
// stimulus and checking for the stop-and-wait sender: message bytes, ack
// packets, timer expiries and noise go in; every burst byte and timer stop
// coming out is checked against a cycle-free predictor of the sender state
// ----------------------------------------------------------------------------

module alternating_bit_sender_core_test;
   import abs_pkg::*;

   localparam int          MSG_LEN     = MSG_LEN_DEF;
   localparam logic [1:0]  CMD_IGNORED = 2'd3;

   // one input item
   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  data;
      logic        pseq;
      logic        pack;
      logic [15:0] pchk;
   } link_event_type;

   // one result item
   typedef struct packed {
      logic        kind;
      logic [7:0]  data;
      logic        seq;
      logic [15:0] chk;
      logic        last;
      logic        restart;
      logic [15:0] tmo;
   } tx_item_type;

   // sender state plus the timeout register
   typedef struct packed {
      logic [15:0]              tmo;
      logic                     seq_bit;
      logic [MSG_LEN-1:0][7:0]  stored;
      logic [15:0]              stored_chk;
      logic [MSG_LEN-1:0][7:0]  assembly;
      logic [4:0]               msg_idx;
      logic [15:0]              msg_sum;
      logic [4:0]               ack_idx;
      logic [15:0]              ack_sum;
   } sender_state_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [15:0] csr_wdata  = '0;

   link_event_type   event_fifo[$];
   tx_item_type      tx_awaited[$];
   sender_state_type model_st;
   sender_state_type gen_st;
   link_event_type   cur_ev;
   int               send_idle_pct  = 16;
   int               recv_stall_pct = 49;
   int               fail_count     = 0;
   int               queued_count   = 0;

   alternating_bit_sender_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // state after reset
   function automatic sender_state_type reset_state();
      sender_state_type st;
      st         = '0;
      st.tmo     = TIMEOUT_RESET;
      st.seq_bit = 1'b1;
      return st;
   endfunction

   // checksum term of one signed byte at its position, mod 2^16
   function automatic logic [15:0] csum_term(logic [7:0] b, int pos);
      int v;
      v = $signed(b);
      return 16'(v * pos + 2);
   endfunction

   // burst of the stored packet, timer restart on its last byte
   function automatic void queue_burst(sender_state_type st);
      tx_item_type it;
      for (int k = 0; k < MSG_LEN; k++) begin
         it         = '0;
         it.kind    = JOB_SEND;
         it.data    = st.stored[k];
         it.seq     = st.seq_bit;
         it.chk     = st.stored_chk;
         it.last    = (k == MSG_LEN - 1);
         it.restart = (k == MSG_LEN - 1);
         it.tmo     = st.tmo;
         tx_awaited.push_back(it);
      end
   endfunction

   // advance the sender by one item, optionally recording what it sends
   function automatic void sender_step(inout sender_state_type st,
                                       input link_event_type ev, input bit record);
      logic [15:0] calc;
      tx_item_type stop;
      case (ev.cmd)
         CMD_MSG: begin
            st.assembly[st.msg_idx] = ev.data;
            st.msg_sum = st.msg_sum + csum_term(ev.data, st.msg_idx);
            st.msg_idx = st.msg_idx + 1;
            if (st.msg_idx == MSG_LEN) begin
               st.seq_bit    = ~st.seq_bit;
               st.stored_chk = st.msg_sum + 16'(st.seq_bit);
               st.stored     = st.assembly;
               st.msg_idx    = '0;
               st.msg_sum    = '0;
               if (record) queue_burst(st);
            end
         end
         CMD_ACK: begin
            st.ack_sum = st.ack_sum + csum_term(ev.data, st.ack_idx);
            st.ack_idx = st.ack_idx + 1;
            if (st.ack_idx == MSG_LEN) begin
               calc       = st.ack_sum + 16'(ev.pseq) + 16'({ev.pack, 1'b0});
               st.ack_idx = '0;
               st.ack_sum = '0;
               if (calc != ev.pchk || ev.pack != st.seq_bit) begin
                  if (record) queue_burst(st);
               end else if (record) begin
                  stop      = '0;
                  stop.kind = JOB_STOP;
                  tx_awaited.push_back(stop);
               end
            end
         end
         CMD_EXPIRE: begin
            if (record) queue_burst(st);
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic link_event_type random_event(logic [1:0] cmd);
      link_event_type ev;
      ev.cmd = cmd;
      case ($urandom_range(7))
         0:       ev.data = 8'h80;
         1:       ev.data = 8'h7f;
         2:       ev.data = 8'hff;
         default: ev.data = 8'($urandom_range(255));
      endcase
      ev.pseq = 1'($urandom_range(1));
      ev.pack = 1'($urandom_range(1));
      ev.pchk = 16'($urandom_range(65535));
      return ev;
   endfunction

   // generator keeps its own copy of the state to build valid ack packets
   function automatic void queue_event(link_event_type ev);
      sender_step(gen_st, ev, 1'b0);
      event_fifo.push_back(ev);
      queued_count++;
   endfunction

   // completes the message under assembly
   function automatic void queue_message();
      do queue_event(random_event(CMD_MSG));
      while (gen_st.msg_idx != 0);
   endfunction

   // completes the ack packet under assembly, with a right or wrong ack bit, optionally corrupted
   function automatic void queue_ack_packet(bit right_ack, bit corrupt);
      link_event_type ev;
      while (gen_st.ack_idx != MSG_LEN - 1) queue_event(random_event(CMD_ACK));
      ev      = random_event(CMD_ACK);
      ev.pack = right_ack ? gen_st.seq_bit : ~gen_st.seq_bit;
      ev.pchk = gen_st.ack_sum + csum_term(ev.data, MSG_LEN - 1) + 16'(ev.pseq)
                + 16'({ev.pack, 1'b0});
      if (corrupt) ev.pchk = ev.pchk ^ 16'($urandom_range(65535, 1));
      queue_event(ev);
   endfunction

   task automatic run_random(int n_items);
      int start;
      int pick;
      start = queued_count;
      while (queued_count - start < n_items) begin
         pick = $urandom_range(99);
         if (pick < 35)      queue_message();
         else if (pick < 58) queue_ack_packet(1'b1, 1'b0);
         else if (pick < 68) queue_ack_packet(1'b0, 1'b0);
         else if (pick < 76) queue_ack_packet(1'b1, 1'b1);
         else if (pick < 86) queue_event(random_event(CMD_EXPIRE));
         else                queue_event(random_event(2'($urandom_range(3))));
      end
   endtask

   // hold off until everything sent has been accepted and answered
   task automatic drain();
      while (event_fifo.size() != 0 || req_tvalid || tx_awaited.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_timeout(logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      model_st.tmo = value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // input driver
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive_proc
      bit go;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) sender_step(model_st, cur_ev, 1'b1);
         if (!req_tvalid || req_tready) begin
            go = event_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct;
            if (go) begin
               cur_ev    = event_fifo.pop_front();
               req_tdata <= {6'd0, cur_ev.pchk, cur_ev.pack, cur_ev.pseq, cur_ev.data};
               req_tuser <= cur_ev.cmd;
            end
            req_tvalid <= go;
         end
      end
   end

   // result back-pressure
   always @(posedge clock) begin
      rsp_tready <= $urandom_range(99) >= recv_stall_pct;
   end

   // ------------------------------------------------------------------
   // result monitor
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_proc
      tx_item_type got;
      tx_item_type want;
      bit          bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind    = rsp_tuser[0];
         got.data    = rsp_tdata[7:0];
         got.seq     = rsp_tdata[8];
         got.chk     = rsp_tdata[24:9];
         got.restart = rsp_tdata[25];
         got.tmo     = rsp_tdata[41:26];
         got.last    = rsp_tlast;
         if (tx_awaited.size() == 0) begin
            want = '0;
            bad  = 1'b1;
         end else begin
            want = tx_awaited.pop_front();
            bad  = got.kind != want.kind || got.data != want.data || got.seq != want.seq
                   || got.chk != want.chk || got.last != want.last
                   || got.restart != want.restart || got.tmo != want.tmo;
         end
         if (bad) begin
            fail_count++;
            if (fail_count <= 10) begin
               if (tx_awaited.size() == 0 && want == '0 && got != '0)
                  $display("%0t: result item with nothing awaited", $realtime);
               $display("%0t: exp kind=%0d byte=%0d seq=%0d chk=%h last=%0d rst=%0d tmo=%0d",
                        $realtime, want.kind, $signed(want.data), want.seq, want.chk,
                        want.last, want.restart, want.tmo);
               $display("%0t: got kind=%0d byte=%0d seq=%0d chk=%h last=%0d rst=%0d tmo=%0d",
                        $realtime, got.kind, $signed(got.data), got.seq, got.chk,
                        got.last, got.restart, got.tmo);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin
      link_event_type ev;
      model_st = reset_state();
      gen_st   = reset_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: resend of the reset packet, ignored command, partial
      // message interleaved with a good ack, then an expiry
      queue_event(random_event(CMD_EXPIRE));
      ev      = random_event(CMD_IGNORED);
      ev.data = 8'hff;
      queue_event(ev);
      ev      = random_event(CMD_MSG);
      ev.data = 8'h80;
      queue_event(ev);
      ev.data = 8'h7f;
      queue_event(ev);
      queue_ack_packet(1'b1, 1'b0);
      queue_event(random_event(CMD_EXPIRE));
      drain();

      // timeout of one, sender idles lightly, receiver stalls often
      write_timeout(16'd1);
      run_random(15);
      drain();

      // largest timeout, idling swapped
      write_timeout(16'hffff);
      send_idle_pct  = 49;
      recv_stall_pct = 16;
      run_random(15);
      drain();

      // zero timeout passes through, no idling at all
      write_timeout(16'd0);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random(15);
      drain();

      write_timeout(16'($urandom_range(65535, 2)));
      run_random(5);
      drain();

      if (fail_count == 0 && tx_awaited.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
